/* rtl/core/cpbt_pkg.sv */
// Shared types, constants and helpers for the changed page bitmap tracker.
package cpbt_pkg;
    localparam int SPACES_DEF = 16;
    localparam int WORDS_DEF = 1024;
    localparam int WORD_BITS = 64;
    localparam int PAGE_W = 16;
    localparam int END_W = 17;
    localparam int SPACE_W = 4;

    typedef enum logic [1:0] {
        ACT_TRACK = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_FIND  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_SET   = 2'd1;
    localparam logic [1:0] ST_OOR   = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [SPACE_W-1:0] space;
        logic [PAGE_W-1:0]  page;
        logic [END_W-1:0]   end_page;
    } req_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_EVAL,
        B_OUT
    } bstate_t;

    // Index of the lowest set bit, in six halving steps.
    function automatic logic [5:0] low_bit(input logic [63:0] w);
        logic [5:0]  r;
        logic [63:0] v;
        r = '0;
        v = w;
        if (v[31:0] == '0) begin r[5] = 1'b1; v = v >> 32; end
        if (v[15:0] == '0) begin r[4] = 1'b1; v = v >> 16; end
        if (v[7:0] == '0) begin r[3] = 1'b1; v = v >> 8; end
        if (v[3:0] == '0) begin r[2] = 1'b1; v = v >> 4; end
        if (v[1:0] == '0) begin r[1] = 1'b1; v = v >> 2; end
        if (v[0] == 1'b0) begin r[0] = 1'b1; end
        return r;
    endfunction
endpackage

/* rtl/core/changed_page_bitmap_tracker.sv */
// Top level of the changed page bitmap tracker.
//  channel | ports           | fields
//  s_      | s_valid/s_ready | action, space, page, end_page
//  m_      | m_valid/m_ready | status, found, next_page
// Track and query pass through queue pop, memory read, update and result steps.
// Find-next reads and evaluates one scanned word at a time via the single memory port.
// After reset a clearing pass of one cycle per memory word (SPACES times
// WORDS_PER_SPACE rounded up to a power of two) runs before the first beat
// leaves the queue. A two-beat queue keeps accepting while the engine works
// or its result waits.
module changed_page_bitmap_tracker import cpbt_pkg::*; #(
    parameter int SPACES = SPACES_DEF,
    parameter int WORDS_PER_SPACE = WORDS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_action,
    input  logic [3:0]        s_space,
    input  logic [15:0]       s_page,
    input  logic [16:0]       s_end_page,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic              m_found,
    output logic [15:0]       m_next_page
);
    req_t in_req, q_req;
    logic q_valid, q_ready;

    assign in_req = '{action: s_action, space: s_space,
                      page: s_page, end_page: s_end_page};

    // Front end buffers requests so the engine can stall on its own.
    cpbt_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_req(in_req),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    // Back end owns the bitmap memory and the extent counters.
    cpbt_engine #(.SPACES(SPACES), .WORDS_PER_SPACE(WORDS_PER_SPACE)) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_found(m_found), .m_next_page(m_next_page)
    );
endmodule

/* rtl/core/cpbt_front.sv */
// Input stage and two-entry request queue in front of the bitmap engine.
module cpbt_front import cpbt_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  req_t                in_req,
    output logic                q_valid,
    input  logic                q_ready,
    output req_t                q_req
);
    req_t       mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
        end
        if (push) mem_reg[wp_reg] <= in_req;
    end
endmodule

/* rtl/core/cpbt_engine.sv */
// Bitmap engine: clears the store, then runs track, query and find-next.
module cpbt_engine import cpbt_pkg::*; #(
    parameter int SPACES = SPACES_DEF,
    parameter int WORDS_PER_SPACE = WORDS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  req_t              q_req,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic              m_found,
    output logic [PAGE_W-1:0] m_next_page
);
    localparam int SW = (SPACES > 1) ? $clog2(SPACES) : 1;
    localparam int WW = (WORDS_PER_SPACE > 1) ? $clog2(WORDS_PER_SPACE) : 1;
    localparam int CW = $clog2(WORDS_PER_SPACE + 1);
    localparam int SCW = $clog2(SPACES + 1);
    localparam int DEPTH = SPACES << WW;
    localparam int AW = SW + WW;

    logic [63:0]   mem [DEPTH];
    logic [63:0]   rd_reg;
    logic [CW-1:0] wcnt_reg [SPACES];
    logic [SCW-1:0] scnt_reg;

    bstate_t state_reg, state_next;
    req_t    req_reg;
    logic [AW-1:0] clr_reg;
    logic [17:0]   w_reg;       // current word index during a scan
    logic [16:0]   p_reg;       // current start page within scan
    logic [1:0]    st_reg;
    logic          fnd_reg;
    logic [PAGE_W-1:0] np_reg;

    logic [17:0] sp_ext, wd_ext, sp_grow, wd_grow;
    logic        sp_ok, wd_ok, known;
    logic [CW-1:0] wlen;
    logic [AW-1:0] addr;
    logic [63:0]  masked;
    logic [5:0]   lb;
    logic [17:0]  hit;

    assign sp_ext = 18'(req_reg.space);
    assign sp_ok  = sp_ext < 18'(SPACES);
    assign known  = sp_ok && (sp_ext < 18'(scnt_reg));
    assign wd_ext = 18'(req_reg.page[PAGE_W-1:6]);
    assign wd_ok  = wd_ext < 18'(WORDS_PER_SPACE);
    assign wlen   = wcnt_reg[SW'(req_reg.space)];
    assign addr   = {SW'(req_reg.space), WW'(w_reg)};
    assign masked = rd_reg & ({64{1'b1}} << p_reg[5:0]);
    assign lb     = low_bit(masked);
    assign hit    = {w_reg[11:0], lb};

    // Grown extents of a track request as it leaves the queue.
    assign sp_grow = 18'({q_req.space, 1'b1});
    assign wd_grow = 18'({q_req.page[PAGE_W-1:6], 1'b1});

    assign q_ready = (state_reg == B_IDLE);
    assign m_valid = (state_reg == B_OUT);
    assign m_status = st_reg;
    assign m_found = fnd_reg;
    assign m_next_page = np_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR: if (clr_reg == AW'(DEPTH - 1)) state_next = B_IDLE;
            B_IDLE:  if (q_valid) state_next = B_READ;
            B_READ:  state_next = B_EVAL;
            B_EVAL: begin
                if (req_reg.action == ACT_FIND && known && masked == '0 &&
                    (w_reg + 18'd1) < 18'(wlen) &&
                    {(w_reg[11:0] + 12'd1), 6'd0} < 18'(req_reg.end_page)) begin
                    state_next = B_READ;
                end else begin
                    state_next = B_OUT;
                end
            end
            B_OUT:   if (m_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_CLEAR;
            clr_reg   <= '0;
            scnt_reg  <= '0;
            for (int i = 0; i < SPACES; i++) wcnt_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR) clr_reg <= clr_reg + AW'(1);
            if (state_reg == B_IDLE && q_valid && q_req.action == ACT_TRACK) begin
                if (18'(q_req.space) >= 18'(scnt_reg))
                    scnt_reg <= (sp_grow > 18'(SPACES)) ? SCW'(SPACES) : SCW'(sp_grow);
                if (18'(q_req.space) < 18'(SPACES) &&
                    18'(q_req.page[PAGE_W-1:6]) >= 18'(wcnt_reg[SW'(q_req.space)])) begin
                    wcnt_reg[SW'(q_req.space)] <= (wd_grow > 18'(WORDS_PER_SPACE)) ?
                        CW'(WORDS_PER_SPACE) : CW'(wd_grow);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_CLEAR) mem[clr_reg] <= '0;
        if (state_reg == B_IDLE && q_valid) begin
            req_reg <= q_req;
            w_reg   <= 18'(q_req.page[PAGE_W-1:6]);
            p_reg   <= 17'(q_req.page);
        end
        if (state_reg == B_READ) rd_reg <= mem[addr];
        if (state_reg == B_EVAL) begin
            st_reg  <= ST_CLEAR;
            fnd_reg <= 1'b0;
            np_reg  <= '0;
            case (req_reg.action)
                ACT_TRACK: if (sp_ok && wd_ok)
                    mem[addr] <= rd_reg | (64'd1 << req_reg.page[5:0]);
                ACT_QUERY: begin
                    if (!known || !wd_ok || wd_ext >= 18'(wlen)) st_reg <= ST_OOR;
                    else st_reg <= {1'b0, rd_reg[req_reg.page[5:0]]};
                end
                ACT_FIND: begin
                    if (known && w_reg < 18'(wlen) && w_reg < 18'(WORDS_PER_SPACE) &&
                        18'(p_reg) < 18'(req_reg.end_page) && masked != '0 &&
                        hit < 18'(req_reg.end_page)) begin
                        fnd_reg <= 1'b1;
                        np_reg  <= hit[PAGE_W-1:0];
                    end
                    w_reg <= w_reg + 18'd1;
                    p_reg <= {w_reg[10:0] + 11'd1, 6'd0};
                end
                default: ;
            endcase
        end
    end
endmodule

/* tb/testbench.sv */
// Self-checking testbench for the changed page bitmap tracker.
`timescale 1ns / 1ps

module testbench import cpbt_pkg::*; ();

    localparam int NSPACE = 16;
    localparam int NWORD = 1024;
    localparam longint CYCLE_LIMIT = 20000000;

    // One expected answer per accepted request beat.
    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [15:0] next_page;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = ACT_NONE;
    logic [3:0]  s_space = '0;
    logic [15:0] s_page = '0;
    logic [16:0] s_end_page = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_found;
    logic [15:0] m_next_page;

    // The predictor keeps its own copy of the bitmap and of the known extents.
    logic [63:0] dirty_words [NSPACE][NWORD];
    int          known_words [NSPACE];
    int          known_spaces;

    answer_t     pending_answers [$];
    int          error_count = 0;
    int          beats_sent = 0;
    int          answers_checked = 0;
    int          finds_hit = 0;
    longint      cycle_count = 0;
    bit          quiet_mode = 1'b0;

    changed_page_bitmap_tracker i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_space     (s_space),
        .s_page      (s_page),
        .s_end_page  (s_end_page),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_found     (m_found),
        .m_next_page (m_next_page)
    );

    always #6 aclk = ~aclk;

    // Grow an extent to 2*index+1, saturating at the capacity.
    function automatic int grow_extent(input int idx, input int cap);
        int n;
        n = 2 * idx + 1;
        return (n > cap) ? cap : n;
    endfunction

    // Apply one request to the predicted state and return the expected answer.
    function automatic answer_t predict_answer(input logic [1:0] act, input int sp,
                                               input int pg, input int end_pg);
        answer_t ans;
        int      w;
        int      p;
        logic [63:0] bits;
        bit      done;
        ans = '0;
        w = pg >> 6;
        done = 1'b0;
        case (act)
            ACT_TRACK: begin
                if (sp >= known_spaces) known_spaces = grow_extent(sp, NSPACE);
                if (w >= known_words[sp]) known_words[sp] = grow_extent(w, NWORD);
                dirty_words[sp][w][pg & 63] = 1'b1;
            end
            ACT_QUERY: begin
                if (sp >= known_spaces || w >= known_words[sp]) ans.status = ST_OOR;
                else ans.status = dirty_words[sp][w][pg & 63] ? ST_SET : ST_CLEAR;
            end
            ACT_FIND: begin
                // Walk words from the start page, skipping empty ones; the first
                // set bit decides the outcome even when it lies past the end page.
                if (sp < known_spaces) begin
                    p = pg;
                    for (int wi = pg >> 6; wi < known_words[sp] && p < end_pg && !done;
                         wi++) begin
                        bits = dirty_words[sp][wi] & ({64{1'b1}} << (p & 63));
                        if (bits != '0) begin
                            done = 1'b1;
                            for (int b = 63; b >= 0; b--)
                                if (bits[b]) p = wi * 64 + b;
                            if (p < end_pg) begin
                                ans.found = 1'b1;
                                ans.next_page = p[15:0];
                            end
                        end else begin
                            p = (wi + 1) * 64;
                        end
                    end
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
    endtask

    // Predict at every accepted request beat, in acceptance order.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            pending_answers.push_back(predict_answer(s_action, s_space, s_page,
                                                     s_end_page));
            beats_sent++;
        end
    end

    // Compare every accepted result beat with the oldest expectation.
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result beat, status", m_status, 0);
            end else begin
                want = pending_answers.pop_front();
                answers_checked++;
                if (want.found) finds_hit++;
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_found !== want.found)
                    report_mismatch("found", m_found, want.found);
                if (m_next_page !== want.next_page)
                    report_mismatch("next_page", m_next_page, want.next_page);
            end
        end
    end

    // The receiver stalls on about 22 percent of cycles unless in a quiet stretch.
    always @(posedge aclk) begin
        m_ready <= quiet_mode || ($urandom_range(0, 99) >= 22);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results pending",
                     cycle_count, pending_answers.size());
            $display("[changed_page_bitmap_tracker] ERROR");
            $finish;
        end
    end

    // Send one request beat. Valid stays high after acceptance so the next beat
    // can follow back to back; each call changes it at most once per edge.
    task automatic send_request(input logic [1:0] act, input int sp, input int pg,
                                input int end_pg);
        while (!quiet_mode && $urandom_range(0, 99) < 22) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= act;
        s_space    <= sp[3:0];
        s_page     <= pg[15:0];
        s_end_page <= end_pg[16:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Hold off the sender until every expected result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // Edge cases: empty store, word boundaries, end bound, the last page,
    // the unused action code and an out-of-range end page.
    task automatic test_directed();
        send_request(ACT_QUERY, 3, 5, 0);            // nothing known yet
        send_request(ACT_FIND, 0, 0, 100);           // unknown space
        send_request(ACT_TRACK, 0, 0, 0);
        send_request(ACT_TRACK, 0, 63, 0);
        send_request(ACT_TRACK, 0, 64, 0);
        send_request(ACT_QUERY, 0, 0, 0);
        send_request(ACT_QUERY, 0, 1, 0);
        send_request(ACT_QUERY, 0, 200, 0);          // past the known words
        send_request(ACT_FIND, 0, 1, 65536);
        send_request(ACT_FIND, 0, 1, 63);            // first set bit sits at the bound
        send_request(ACT_FIND, 0, 10, 10);           // empty range
        send_request(ACT_NONE, 9, 65535, 131071);
        send_request(ACT_TRACK, 15, 65535, 0);       // last page, saturates both extents
        send_request(ACT_QUERY, 15, 65535, 0);
        send_request(ACT_FIND, 15, 0, 65536);        // full scan of the highest space
        send_request(ACT_FIND, 15, 65535, 65536);
        send_request(ACT_FIND, 15, 65535, 65535);
        send_request(ACT_TRACK, 7, 12345, 0);
        send_request(ACT_QUERY, 7, 12344, 0);
        send_request(ACT_QUERY, 7, 12345, 0);
        send_request(ACT_QUERY, 2, 0, 0);            // known space, no words yet
        send_request(ACT_FIND, 3, 0, 131071);
        send_request(ACT_FIND, 7, 65, 12346);
        wait_drained();
    endtask

    // Random mix, mostly low pages so that scans stay short.
    task automatic test_random(input int count);
        int          roll;
        int          sp;
        int          pg;
        int          end_pg;
        logic [1:0]  act;
        for (int i = 0; i < count; i++) begin
            quiet_mode = (i >= count / 3) && (i < count / 3 + 80);
            roll = $urandom_range(0, 99);
            act = (roll < 40) ? ACT_TRACK : (roll < 70) ? ACT_QUERY :
                  (roll < 97) ? ACT_FIND : ACT_NONE;
            sp = $urandom_range(0, 15);
            pg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 1023);
            roll = $urandom_range(0, 9);
            end_pg = (roll < 2) ? 65536 : (roll < 3) ? $urandom_range(0, 131071)
                                        : pg + $urandom_range(0, 600);
            send_request(act, sp, pg, end_pg);
            if (i == count / 2) wait_drained();
        end
        quiet_mode = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(530);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("Sent %0d request beats and checked %0d results in %0d cycles.",
                 beats_sent, answers_checked, cycle_count);
        $display("Tracks, queries, finds (%0d hits) and the unused action were covered.",
                 finds_hit);
        if (error_count == 0 && pending_answers.size() == 0) begin
            $display("[changed_page_bitmap_tracker] OK");
        end else begin
            $display("[changed_page_bitmap_tracker] ERROR");
        end
        $finish;
    end

    initial begin
        for (int s = 0; s < NSPACE; s++) begin
            known_words[s] = 0;
            for (int w = 0; w < NWORD; w++) dirty_words[s][w] = '0;
        end
        known_spaces = 0;
    end
endmodule
